@@ src/hole_list_segment_allocator_unit_macros.svh @@
// Assertion macros shared by the hole list allocator RTL.
`ifndef HOLE_LIST_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define HOLE_LIST_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HLSA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hole list allocator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HLSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hole list allocator check failed");

`else

`define HLSA_ASSERT_IMP(label, ante, cons)
`define HLSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/hlsa_pkg.sv @@
// Package with the shared constants and types of the hole list allocator.
package hlsa_pkg;

   // Default sizing of the hole table and the address space.
   localparam int DEF_MAX_HOLES = 64;
   localparam int DEF_ADDR_BITS = 16;

   typedef logic [1:0] policy_type;
   typedef logic [1:0] status_type;
   typedef logic       op_type;

   // Hole selection policies; the unused code behaves as first fit.
   localparam policy_type FIRST = 2'd0;
   localparam policy_type BEST  = 2'd1;
   localparam policy_type WORST = 2'd2;

   // Result status codes.
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_COMPACT = 2'd1;
   localparam status_type ST_OOM     = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   // Request operation codes.
   localparam op_type OP_ALLOC  = 1'b0;
   localparam op_type OP_APPEND = 1'b1;

endpackage

@@ src/hlsa_if.sv @@
// Request and response channel interfaces of the hole list allocator.
interface hlsa_req_if
   import hlsa_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) ();
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [ADDR_BITS:0]   req_size;
   logic [ADDR_BITS-1:0] hole_base_in;

   modport source (output valid, output op, output req_size, output hole_base_in,
                   input ready);
   modport sink (input valid, input op, input req_size, input hole_base_in,
                 output ready);
endinterface

interface hlsa_rsp_if
   import hlsa_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [ADDR_BITS-1:0] seg_base;

   modport source (output valid, output status, output seg_base, input ready);
   modport sink (input valid, input status, input seg_base, output ready);
endinterface

@@ src/hlsa_hole_ram.sv @@
// Single write port, single registered read port memory for the hole table.
module hlsa_hole_ram
   import hlsa_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_HOLES,
   parameter int WIDTH = 2 * DEF_ADDR_BITS + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read; reads and writes go to different entries.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ src/hole_list_segment_allocator_unit.sv @@
// Top level of the hole list segment allocator: sequencer, scan unit and table.
//
// Usage: req_chan carries an operation (allocate or append), a size and, for
// append, a hole base. rsp_chan returns one status and segment base for each
// request. csr_wr_en/csr_wr_data load the fit policy (first, best, worst fit)
// and may be written only while the block is idle.
// An append writes its entry when it is taken (or reports full), then posts its
// result. An allocate scans the table through one read port, one entry a cycle,
// then decides; when the chosen hole is used up it moves the later entries down
// by one place, then posts the result. The single read port bounds the scan.
// A new request is taken only after the previous one has posted its result.
// The result waits in an output register; the block accepts the next request
// while the receiver stalls, and holds a finished result until the register
// frees. Reset (synchronous, active high) empties the table, selects first fit
// and drops any pending result; table contents are not cleared.
`include "hole_list_segment_allocator_unit_macros.svh"

module hole_list_segment_allocator_unit
   import hlsa_pkg::*;
#(
   parameter int MAX_HOLES = DEF_MAX_HOLES,
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic         clock,
   input  logic         reset,
   hlsa_req_if.sink     req_chan,
   hlsa_rsp_if.source   rsp_chan,
   input  logic         csr_wr_en,
   input  policy_type   csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_HOLES);
   localparam int CNT_W = $clog2(MAX_HOLES + 1);
   localparam int LEN_W = ADDR_BITS + 1;
   localparam int SUM_W = LEN_W + CNT_W;
   localparam int ENT_W = ADDR_BITS + LEN_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HOLES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   policy_type           policy_ff, policy_in;
   logic [LEN_W-1:0]     size_ff, size_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic                 have_ff, have_in;
   logic [IDX_W-1:0]     pick_idx_ff, pick_idx_in;
   logic [ADDR_BITS-1:0] pick_base_ff, pick_base_in;
   logic [LEN_W-1:0]     best_ff, best_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   status_type           res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0] res_seg_ff, res_seg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_seg_ff, rsp_seg_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENT_W-1:0]     wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENT_W-1:0]     rd_data;
   logic [ADDR_BITS-1:0] rd_base;
   logic [LEN_W-1:0]     rd_len;
   logic                 fits;
   logic                 take;

   // Hole table: base in the upper bits, length in the lower bits.
   hlsa_hole_ram #(
      .DEPTH (MAX_HOLES),
      .WIDTH (ENT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_base = rd_data[ENT_W-1:LEN_W];
   assign rd_len  = rd_data[LEN_W-1:0];

   // Channel outputs.
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.seg_base = rsp_seg_ff;

   // Shared compare unit: decides whether the entry read back replaces the pick.
   always_comb begin
      fits = (rd_len >= size_ff);
      case (policy_ff)
         BEST: begin
            take = fits && (!have_ff || (rd_len < best_ff));
         end
         WORST: begin
            take = (rd_len > best_ff);
         end
         default: begin
            take = fits && !have_ff;
         end
      endcase
   end

   // Sequencer next-state and table access.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      policy_in     = policy_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      have_in       = have_ff;
      pick_idx_in   = pick_idx_ff;
      pick_base_in  = pick_base_ff;
      best_in       = best_ff;
      sum_in        = sum_ff;
      res_status_in = res_status_ff;
      res_seg_in    = res_seg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_seg_in    = rsp_seg_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      // The output register frees once its transfer completes.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Policy register write.
      if (csr_wr_en) begin
         policy_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               size_in    = req_chan.req_size;
               res_seg_in = '0;
               if (req_chan.op == OP_APPEND) begin
                  if (count_ff >= MAX_CNT) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[IDX_W-1:0];
                     wr_data       = {req_chan.hole_base_in, req_chan.req_size};
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = ST_OK;
                  end
                  state_in = S_FINISH;
               end else begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  have_in  = 1'b0;
                  best_in  = '0;
                  sum_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Evaluate the entry read in the previous cycle.
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(rd_len);
               if (take) begin
                  have_in      = 1'b1;
                  pick_idx_in  = pend_idx_ff;
                  pick_base_in = rd_base;
                  best_in      = rd_len;
               end
            end
            // Issue the next read while entries remain.
            if (idx_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            if (have_ff && (best_ff >= size_ff)) begin
               res_status_in = ST_OK;
               res_seg_in    = pick_base_ff;
               if (best_ff == size_ff) begin
                  // Hole used up: move the later entries down by one.
                  idx_in   = CNT_W'(pick_idx_ff) + CNT_W'(1);
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = pick_idx_ff;
                  wr_data  = {pick_base_ff + size_ff[ADDR_BITS-1:0], best_ff - size_ff};
                  state_in = S_FINISH;
               end
            end else begin
               res_seg_in    = '0;
               res_status_in = (sum_ff >= SUM_W'(size_ff)) ? ST_COMPACT : ST_OOM;
               state_in      = S_FINISH;
            end
         end

         S_SHIFT: begin
            // Write back the entry read in the previous cycle one place lower.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - IDX_W'(1);
               wr_data = rd_data;
            end
            if (idx_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_seg_in    = res_seg_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and output registers.
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      have_ff       <= have_in;
      pick_idx_ff   <= pick_idx_in;
      pick_base_ff  <= pick_base_in;
      best_ff       <= best_in;
      sum_ff        <= sum_in;
      res_status_ff <= res_status_in;
      res_seg_ff    <= res_seg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seg_ff    <= rsp_seg_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         policy_ff    <= FIRST;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         policy_ff    <= policy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The fill count never runs past the table size.
   `HLSA_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= MAX_CNT)

   // A successful append grows the table by exactly one entry.
   `HLSA_ASSERT_NEXT(a_append_count,
      req_chan.valid && req_chan.ready && (req_chan.op == OP_APPEND) && (count_ff < MAX_CNT),
      count_ff == $past(count_ff) + CNT_W'(1))

   // A failed request reports a zero segment base.
   `HLSA_ASSERT_IMP(a_fail_zero_base,
      rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_seg_ff == '0)

   // The removal pass never writes below entry zero.
   `HLSA_ASSERT_IMP(a_shift_index, (state_ff == S_SHIFT) && pend_ff, pend_idx_ff != '0)

   // The read pointer stays within the filled part of the table.
   `HLSA_ASSERT_IMP(a_scan_pointer, state_ff == S_SCAN, idx_ff <= count_ff)

endmodule
